@@ design/ade_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ade_pkg
// Widths and fixed-point constants shared by the attack/decay envelope block.
// ----------------------------------------------------------------------------
package ade_pkg;

	localparam int AMP_FRAC_BITS  = 24;
	localparam int TIME_FRAC_BITS = 16;

	localparam int AMP_W  = AMP_FRAC_BITS + 1;   // Q1.24 level
	localparam int TIME_W = 24;                  // Q8.16 seconds
	localparam int RATE_W = 18;                  // sample rate in Hz

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
	localparam logic [AMP_W-1:0]  AMP_ONE    = AMP_W'(1) << AMP_FRAC_BITS;

endpackage : ade_pkg
`default_nettype wire

@@ design/ade_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ade_if
// Valid/ready channels for envelope sample items and envelope result items.
// ----------------------------------------------------------------------------
interface ade_sample_if import ade_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] attack_time;
	logic [TIME_W-1:0] decay_time;
	logic              gate;
	logic              hard_reset;

	modport source (output valid, attack_time, decay_time, gate, hard_reset, input ready);
	modport sink   (input valid, attack_time, decay_time, gate, hard_reset, output ready);
endinterface : ade_sample_if

interface ade_env_if import ade_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [AMP_W-1:0] amplitude;
	logic             finished;
	logic             phase_flag;

	modport source (output valid, amplitude, finished, phase_flag, input ready);
	modport sink   (input valid, amplitude, finished, phase_flag, output ready);
endinterface : ade_env_if
`default_nettype wire

@@ design/attack_decay_envelope.sv @@
`default_nettype none
// Sequence: an item that attacks or decays with a nonzero time passes through a
//   multiply, 41 restoring-divider iterations and an update; an item that is
//   idle, full or has time zero goes straight to the update.
// Flow: sample.ready is low from accept until the update, which waits until the
//   output register is free, so the shared serial divider holds one item at a time.
// Reset (arst_n low): idle, level 0, edge history 0, sample_rate 44100.
// ----------------------------------------------------------------------------
// attack_decay_envelope
// Linear attack/decay envelope, one result item per sample item. Step size is
// 2^40 / (sample_rate * time), found by a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module attack_decay_envelope import ade_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [RATE_W-1:0] cfg_wdata,
	ade_sample_if.sink             sample,
	ade_env_if.source              envelope
);

	// envelope phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ATTACK = 2'd1;
	localparam logic [1:0] PH_FULL   = 2'd2;
	localparam logic [1:0] PH_DECAY  = 2'd3;

	// sequencer
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	// divider geometry: numerator is the single bit 2^NUM_BIT
	localparam int NUM_BIT = AMP_FRAC_BITS + TIME_FRAC_BITS;
	localparam int Q_W     = NUM_BIT + 1;
	localparam int PROD_W  = RATE_W + TIME_W;
	localparam int CNT_W   = $clog2(Q_W);

	logic [1:0]        state_q;
	logic [RATE_W-1:0] rate_q;
	logic [1:0]        phase_q;
	logic [AMP_W-1:0]  level_q;
	logic              prev_gate_q;
	logic              prev_hr_q;
	logic              gate_q;
	logic              flag_q;
	logic [TIME_W-1:0] time_q;
	logic [PROD_W-1:0] div_q;      // divisor rate*time
	logic [PROD_W-1:0] rem_q;
	logic [Q_W-1:0]    quo_q;
	logic [CNT_W-1:0]  cnt_q;      // numerator bit being brought down

	logic              out_valid_q;
	logic [AMP_W-1:0]  out_amp_q;
	logic              out_fin_q;
	logic              out_flag_q;

	// ---- accept: apply gate / hard-reset edges before stepping ----
	logic              accept;
	logic [1:0]        ph_edge;
	logic [AMP_W-1:0]  lv_edge;
	logic [TIME_W-1:0] t_sel;
	logic              needs_div;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		ph_edge = phase_q;
		lv_edge = level_q;
		if (!prev_gate_q && sample.gate) begin
			ph_edge = PH_ATTACK;
		end
		// hard reset wins for the level
		if (!prev_hr_q && sample.hard_reset) begin
			ph_edge = PH_ATTACK;
			lv_edge = '0;
		end
		t_sel     = (ph_edge == PH_ATTACK) ? sample.attack_time : sample.decay_time;
		needs_div = ((ph_edge == PH_ATTACK) || (ph_edge == PH_DECAY)) && (t_sel != '0);
	end

	// ---- shared divider step ----
	logic [PROD_W:0]   rem_sh;
	logic [PROD_W+1:0] rem_diff;
	logic              q_bit;

	always_comb begin
		rem_sh   = {rem_q, (cnt_q == CNT_W'(NUM_BIT))};
		rem_diff = {1'b0, rem_sh} - {2'b00, div_q};
		q_bit    = !rem_diff[PROD_W+1];
	end

	// ---- update: step clamp, then attack / full / decay move ----
	logic [AMP_W-1:0] step;
	logic [AMP_W:0]   sum;
	logic [1:0]       ph_next;
	logic [AMP_W-1:0] lv_next;
	logic             fin_next;
	logic             flag_next;
	logic             out_free;

	assign out_free = !out_valid_q || envelope.ready;

	always_comb begin
		// tiny step rounds up to one LSB; anything at or past 1.0 acts as 1.0
		if (quo_q == '0) begin
			step = AMP_W'(1);
		end else if (quo_q >= Q_W'(AMP_ONE)) begin
			step = AMP_ONE;
		end else begin
			step = quo_q[AMP_W-1:0];
		end
		sum       = {1'b0, level_q} + {1'b0, step};
		ph_next   = phase_q;
		lv_next   = level_q;
		fin_next  = 1'b0;
		flag_next = flag_q;
		unique case (phase_q)
			PH_ATTACK: begin
				flag_next = 1'b0;
				if (sum >= {1'b0, AMP_ONE}) begin
					lv_next = AMP_ONE;
					ph_next = PH_FULL;
				end else begin
					lv_next = sum[AMP_W-1:0];
				end
			end
			PH_FULL: begin
				flag_next = 1'b1;
				if (!gate_q) begin
					ph_next = PH_DECAY;
				end
			end
			PH_DECAY: begin
				flag_next = 1'b1;
				if (step >= level_q) begin
					lv_next  = '0;
					fin_next = 1'b1;
					ph_next  = PH_IDLE;
				end else begin
					lv_next = level_q - step;
				end
			end
			PH_IDLE: begin
			end
		endcase
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_RESET;
			phase_q     <= PH_IDLE;
			level_q     <= '0;
			prev_gate_q <= 1'b0;
			prev_hr_q   <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			// a new result replaces the one leaving on the same edge
			if ((state_q == ST_APPLY) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (envelope.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q     <= ph_edge;
						level_q     <= lv_edge;
						prev_gate_q <= sample.gate;
						prev_hr_q   <= sample.hard_reset;
						state_q     <= needs_div ? ST_MUL : ST_APPLY;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						phase_q     <= ph_next;
						level_q     <= lv_next;
						flag_q      <= flag_next;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// ---- datapath: times, divider, result register ----
	always_ff @(posedge clk) begin
		if (accept) begin
			gate_q <= sample.gate;
			time_q <= t_sel;
			quo_q  <= Q_W'(AMP_ONE);   // time zero: full step
		end
		if (state_q == ST_MUL) begin
			// zero rate counts as one hertz
			div_q <= PROD_W'((rate_q == '0) ? RATE_W'(1) : rate_q) * PROD_W'(time_q);
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CNT_W'(NUM_BIT);
		end
		if (state_q == ST_DIV) begin
			rem_q <= q_bit ? rem_diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if ((state_q == ST_APPLY) && out_free) begin
			out_amp_q  <= lv_next;
			out_fin_q  <= fin_next;
			out_flag_q <= flag_next;
		end
	end

	assign envelope.valid      = out_valid_q;
	assign envelope.amplitude  = out_amp_q;
	assign envelope.finished   = out_fin_q;
	assign envelope.phase_flag = out_flag_q;

`ifndef SYNTHESIS
	// one item at a time: no accept on the cycle after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("item accepted while previous item in flight");

	// level never passes 1.0
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= AMP_ONE)
		else $error("envelope level above full scale");

	// finished only comes with a zero level
	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(envelope.valid && envelope.finished) |-> (envelope.amplitude == '0))
		else $error("finished with nonzero amplitude");

	// a result only appears as the sequencer leaves its update state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(envelope.valid) |-> ($past(state_q) == ST_APPLY))
		else $error("result item without update");
`endif

endmodule : attack_decay_envelope
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for attack_decay_envelope. Sample items are driven from
// a queue, every accepted item advances a local envelope model, and each
// envelope item coming back is compared field by field with the model.
// ----------------------------------------------------------------------------
module tb;
	import ade_pkg::*;

	localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
	localparam int DRAIN_CYCLES = 60;    // wait before the final check
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [1:0] {PH_IDLE, PH_ATTACK, PH_FULL, PH_DECAY} env_phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] attack_time;
		logic [TIME_W-1:0] decay_time;
		logic              gate;
		logic              hard_reset;
		logic              drain_first;  // hold back until all results are in
	} stim_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             finished;
		logic             phase_flag;
	} env_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [RATE_W-1:0] cfg_wdata = '0;

	ade_sample_if sample_ch ();
	ade_env_if    env_ch ();

	attack_decay_envelope dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.envelope (env_ch)
	);

	always #5 clk = ~clk;

	// envelope model state, same reset values as the block
	env_phase_t        env_phase     = PH_IDLE;
	logic [AMP_W-1:0]  env_level     = '0;
	logic              env_prev_gate = 1'b0;
	logic              env_prev_hres = 1'b0;
	logic              env_flag      = 1'b0;
	logic [RATE_W-1:0] env_rate      = RATE_RESET;

	stim_t sample_q[$];
	env_t  expected_env_q[$];

	int src_idle_pct = 8;
	int snk_idle_pct = 70;
	int n_sent       = 0;
	int n_got        = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int queued_items = 0;

	// generator view of the last levels queued, to place edges
	logic last_gate = 1'b0;
	logic last_hres = 1'b0;

	// per-sample increment: 2^40 / (rate * time), floor of one LSB
	function automatic logic [63:0] step_size(logic [TIME_W-1:0] t);
		logic [63:0] r;
		logic [63:0] s;
		r = (env_rate == '0) ? 64'd1 : 64'(env_rate);
		if (t == '0)
			return 64'(AMP_ONE);
		s = (64'd1 << (AMP_FRAC_BITS + TIME_FRAC_BITS)) / (r * 64'(t));
		return (s == 64'd0) ? 64'd1 : s;
	endfunction

	function automatic env_t advance_envelope(stim_t s);
		env_t        e;
		logic [63:0] st;
		logic [63:0] lv;
		e.finished = 1'b0;
		// hard reset edge wins over gate edge: both start attack, only it clears
		if (!env_prev_gate && s.gate)
			env_phase = PH_ATTACK;
		if (!env_prev_hres && s.hard_reset) begin
			env_phase = PH_ATTACK;
			env_level = '0;
		end
		env_prev_gate = s.gate;
		env_prev_hres = s.hard_reset;
		case (env_phase)
			PH_ATTACK: begin
				env_flag = 1'b0;
				lv = 64'(env_level) + step_size(s.attack_time);
				if (lv >= 64'(AMP_ONE)) begin
					env_level = AMP_ONE;
					env_phase = PH_FULL;
				end else begin
					env_level = lv[AMP_W-1:0];
				end
			end
			PH_FULL: begin
				env_flag = 1'b1;
				if (!s.gate)
					env_phase = PH_DECAY;
			end
			PH_DECAY: begin
				env_flag = 1'b1;
				st = step_size(s.decay_time);
				if (st >= 64'(env_level)) begin
					env_level  = '0;
					e.finished = 1'b1;
					env_phase  = PH_IDLE;
				end else begin
					env_level = env_level - st[AMP_W-1:0];
				end
			end
			default: ;
		endcase
		e.amplitude  = env_level;
		e.phase_flag = env_flag;
		return e;
	endfunction

	// time that makes a ramp take about k samples at the current rate
	function automatic logic [TIME_W-1:0] time_for_steps(int unsigned k);
		logic [63:0] r;
		logic [63:0] t;
		r = (env_rate == '0) ? 64'd1 : 64'(env_rate);
		t = (64'(k) << TIME_FRAC_BITS) / r;
		t = t + 64'($urandom_range(0, t[31:0] >> 3));
		if (t > 64'hFF_FFFF)
			t = 64'hFF_FFFF;
		return t[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] pick_time(int unsigned k);
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return TIME_W'($urandom());
		return time_for_steps(k);
	endfunction

	function automatic logic [TIME_W-1:0] noise_time();
		if ($urandom_range(0, 1) == 0)
			return TIME_W'($urandom());
		return TIME_W'($urandom_range(0, 63));
	endfunction

	task automatic push_item(logic g, logic h, logic [TIME_W-1:0] at,
			logic [TIME_W-1:0] dt, logic drain = 1'b0);
		stim_t s;
		s.attack_time = at;
		s.decay_time  = dt;
		s.gate        = g;
		s.hard_reset  = h;
		s.drain_first = drain;
		sample_q.push_back(s);
		last_gate = g;
		last_hres = h;
		queued_items++;
	endtask

	// mostly whole notes (rise, hold, release) with random content,
	// some pure noise items in between
	task automatic add_notes(int n);
		int          target;
		int          i;
		int unsigned k_att;
		int unsigned k_dec;
		int unsigned n_on;
		int unsigned n_off;
		logic [TIME_W-1:0] at;
		logic [TIME_W-1:0] dt;
		logic g;
		logic h;
		target = queued_items + n;
		while (queued_items < target) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 6))
					push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						noise_time(), noise_time());
			end else begin
				k_att = $urandom_range(1, 40);
				k_dec = $urandom_range(1, 40);
				at = pick_time(k_att);
				dt = pick_time(k_dec);
				push_item(1'b0, 1'b0, at, dt, $urandom_range(0, 39) == 0);
				n_on = $urandom_range(1, k_att + 8);
				for (i = 0; i < n_on; i++) begin
					if ($urandom_range(0, 9) == 0)
						at = pick_time(k_att);
					// a one-sample gate dip gives a retrigger
					g = (i == 0) || ($urandom_range(0, 14) != 0);
					if (i == 0)
						h = ($urandom_range(0, 3) == 0);
					else
						h = ($urandom_range(0, 7) == 0) ? ~last_hres : last_hres;
					push_item(g, h, at, dt);
				end
				n_off = $urandom_range(1, k_dec + 8);
				for (i = 0; i < n_off; i++) begin
					if ($urandom_range(0, 9) == 0)
						dt = pick_time(k_dec);
					push_item(1'b0, last_hres, at, dt);
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (sample_q.size() != 0 || sample_ch.valid || n_sent != n_got)
			@(posedge clk);
	endtask

	task automatic set_rate(logic [RATE_W-1:0] r);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		env_rate   = r;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// sender: a new item only goes up once the bus is free
	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			sample_ch.valid       <= 1'b0;
			sample_ch.attack_time <= '0;
			sample_ch.decay_time  <= '0;
			sample_ch.gate        <= 1'b0;
			sample_ch.hard_reset  <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_env_q.push_back(advance_envelope({sample_ch.attack_time,
					sample_ch.decay_time, sample_ch.gate, sample_ch.hard_reset, 1'b0}));
				n_sent <= n_sent + 1;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				go = 1'b0;
				if (sample_q.size() > 0) begin
					go = ($urandom_range(0, 99) >= src_idle_pct);
					if (sample_q[0].drain_first &&
							(n_sent != n_got || (sample_ch.valid && sample_ch.ready)))
						go = 1'b0;
				end
				if (go) begin
					sample_ch.attack_time <= sample_q[0].attack_time;
					sample_ch.decay_time  <= sample_q[0].decay_time;
					sample_ch.gate        <= sample_q[0].gate;
					sample_ch.hard_reset  <= sample_q[0].hard_reset;
					void'(sample_q.pop_front());
				end
				sample_ch.valid <= go;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		env_t want;
		if (!arst_n) begin
			env_ch.ready <= 1'b0;
		end else begin
			if (env_ch.valid && env_ch.ready) begin
				n_got <= n_got + 1;
				if (expected_env_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected envelope item: amplitude %0d finished %0b flag %0b",
							env_ch.amplitude, env_ch.finished, env_ch.phase_flag);
					mismatches++;
				end else begin
					want = expected_env_q.pop_front();
					if (env_ch.amplitude !== want.amplitude ||
							env_ch.finished !== want.finished ||
							env_ch.phase_flag !== want.phase_flag) begin
						if (mismatches < MAX_REPORTS)
							$display({"envelope mismatch: amplitude exp %0d got %0d, ",
								"finished exp %0b got %0b, flag exp %0b got %0b"},
								want.amplitude, env_ch.amplitude, want.finished,
								env_ch.finished, want.phase_flag, env_ch.phase_flag);
						mismatches++;
					end
				end
			end
			env_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) || (env_ch.valid && env_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender rarely idle, receiver stalls a lot; reset sample rate
		src_idle_pct = 8;
		snk_idle_pct = 70;
		push_item(1'b0, 1'b0, 24'd0, 24'd0);            // idle from reset
		push_item(1'b1, 1'b0, 24'd0, 24'd0);            // instant attack to full
		push_item(1'b1, 1'b0, 24'd0, 24'd0);            // full hold
		push_item(1'b0, 1'b0, 24'd0, 24'hFF_FFFF);      // release into decay
		push_item(1'b0, 1'b0, 24'd0, 24'hFF_FFFF);      // slowest decay, one LSB
		push_item(1'b1, 1'b0, 24'hFF_FFFF, 24'd0);      // retrigger, lands exactly on 1.0
		push_item(1'b0, 1'b0, 24'hFF_FFFF, 24'd0);      // full to decay
		push_item(1'b0, 1'b0, 24'hFF_FFFF, 24'd0);      // instant decay undershoot
		push_item(1'b0, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF); // idle holds flag
		push_item(1'b1, 1'b1, 24'd20, 24'd0);           // both edges at once
		push_item(1'b0, 1'b1, 24'd20, 24'd0);           // attack ignores low gate
		push_item(1'b1, 1'b0, 24'h80_0000, 24'd0);      // gate rise mid attack
		push_item(1'b0, 1'b0, 24'd0, 24'd0);            // saturate with gate low
		push_item(1'b1, 1'b0, 24'd0, 24'd0);            // gate rise while full
		push_item(1'b1, 1'b1, 24'h7F_FFFF, 24'd0);      // hard reset mid note
		push_item(1'b0, 1'b0, 24'd0, 24'h55_5555);
		push_item(1'b0, 1'b0, 24'd0, 24'h55_5555);
		push_item(1'b0, 1'b0, 24'd0, 24'd30);
		add_notes(205);
		wait_drained();

		// highest rate: long times truncate the step to zero
		set_rate(18'h3_FFFF);
		push_item(1'b0, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF);
		push_item(1'b1, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF);
		push_item(1'b1, 1'b0, 24'hFF_FFFF, 24'd0);
		add_notes(205);
		wait_drained();

		// roles swapped: sender idles a lot, receiver rarely stalls
		src_idle_pct = 70;
		snk_idle_pct = 8;
		set_rate('0);                                    // counts as one hertz
		push_item(1'b0, 1'b0, 24'd1, 24'd1);
		push_item(1'b0, 1'b1, 24'd1, 24'd1);
		push_item(1'b0, 1'b1, 24'd1, 24'd1);
		push_item(1'b0, 1'b0, 24'd1, 24'd1);
		add_notes(205);
		wait_drained();

		set_rate(18'd1000);
		add_notes(205);
		wait_drained();

		// no idling at all
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_rate(18'd192000);
		add_notes(205);
		wait_drained();

		set_rate(18'd48000);
		add_notes(205);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && expected_env_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule : tb
`default_nettype wire
